// File: rtl/core/d96r_pkg.sv
// Types and constants shared by the decimal round unit.
`timescale 1ns / 1ps

package d96r_pkg;

  localparam logic [2:0] CMD_NEGATE   = 3'd0;
  localparam logic [2:0] CMD_TRUNCATE = 3'd1;
  localparam logic [2:0] CMD_ROUND    = 3'd2;
  localparam logic [2:0] CMD_BANKER   = 3'd3;
  localparam logic [2:0] CMD_FLOOR    = 3'd4;

  // Divide-by-ten of a 20-bit value: q = (n * RECIP10) >> RECIP_SHIFT, exact for n < 2**22.
  localparam int unsigned RECIP_SHIFT = 23;
  localparam logic [22:0] RECIP10     = 23'd838861;

  localparam int unsigned LIMB_W = 16;
  localparam int unsigned NLIMBS = 6;

  typedef struct packed {
    logic [2:0]  command;
    logic [63:0] mant_low;
    logic [31:0] mant_high;
    logic [7:0]  scale;
    logic        sign;
  } in_item_t;

  typedef struct packed {
    logic [63:0] out_mant_low;
    logic [31:0] out_mant_high;
    logic [4:0]  out_scale;
    logic        out_sign;
    logic        error;
  } out_item_t;

  typedef struct packed {
    logic        valid;
    logic        err;
    logic [2:0]  cmd;
    logic        sign;
    logic [4:0]  scale;
    logic [95:0] mag;
    logic [3:0]  rem;
    logic [3:0]  last;
    logic        rest;
  } stage_t;

endpackage

// File: rtl/core/decimal96_round_unit.sv
// Top level of the 96-bit decimal negate, truncate, round and floor unit.
`timescale 1ns / 1ps

// One item enters per clock and busy is always low. Each item passes through a fixed
// pipeline of 6*MAX_SCALE + 2 register stages: one input stage, six stages per
// decimal digit (one 16-bit limb of the divide-by-ten chain in each), and a final
// rounding and output stage. The result is therefore shown 6*MAX_SCALE + 1 cycles
// after the item is accepted, whatever the scale or command, and out_valid is a
// single-cycle strobe that the receiver must take in the cycle it is shown.
module decimal96_round_unit #(
  parameter int MAX_SCALE = 28
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  d96r_pkg::in_item_t  in_data,
  output logic                out_valid,
  output d96r_pkg::out_item_t out_data
);

  localparam int NSTG = MAX_SCALE * d96r_pkg::NLIMBS;

  d96r_pkg::stage_t pipe_r [0:NSTG];
  d96r_pkg::stage_t in_nxt;
  logic             out_valid_r;
  d96r_pkg::out_item_t out_data_r;

  assign busy = 1'b0;

  always_comb begin
    in_nxt       = '0;
    in_nxt.valid = start;
    in_nxt.err   = (in_data.scale > 8'(MAX_SCALE)) ||
                   (in_data.command > d96r_pkg::CMD_FLOOR);
    in_nxt.cmd   = in_data.command;
    in_nxt.sign  = in_data.sign;
    in_nxt.scale = in_data.scale[4:0];
    in_nxt.mag   = {in_data.mant_high, in_data.mant_low};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pipe_r[0].valid <= 1'b0;
    end else begin
      pipe_r[0].valid <= in_nxt.valid;
    end
    pipe_r[0].err   <= in_nxt.err;
    pipe_r[0].cmd   <= in_nxt.cmd;
    pipe_r[0].sign  <= in_nxt.sign;
    pipe_r[0].scale <= in_nxt.scale;
    pipe_r[0].mag   <= in_nxt.mag;
    pipe_r[0].rem   <= in_nxt.rem;
    pipe_r[0].last  <= in_nxt.last;
    pipe_r[0].rest  <= in_nxt.rest;
  end

  for (genvar s = 0; s < NSTG; s++) begin : g_stage
    localparam int DIG  = s / d96r_pkg::NLIMBS;
    localparam int LIMB = d96r_pkg::NLIMBS - 1 - (s % d96r_pkg::NLIMBS);

    d96r_pkg::stage_t st_nxt;
    logic        active;
    logic [19:0] cur;
    logic [42:0] prod;
    logic [15:0] quo;
    logic [19:0] q10;
    logic [3:0]  rmd;

    always_comb begin
      active = !pipe_r[s].err && (pipe_r[s].cmd != d96r_pkg::CMD_NEGATE) &&
               (pipe_r[s].scale > 5'(DIG));
      // The first limb of each digit starts with no carried remainder.
      cur  = {(LIMB == d96r_pkg::NLIMBS - 1) ? 4'd0 : pipe_r[s].rem,
              pipe_r[s].mag[LIMB*d96r_pkg::LIMB_W +: d96r_pkg::LIMB_W]};
      prod = 43'(cur) * 43'(d96r_pkg::RECIP10);
      quo  = prod[d96r_pkg::RECIP_SHIFT +: 16];
      q10  = {1'b0, quo, 3'b000} + {3'b000, quo, 1'b0};
      rmd  = 4'(cur - q10);
      st_nxt = pipe_r[s];
      if (active) begin
        st_nxt.mag[LIMB*d96r_pkg::LIMB_W +: d96r_pkg::LIMB_W] = quo;
        st_nxt.rem = rmd;
        if (LIMB == 0) begin
          st_nxt.rest = pipe_r[s].rest || (pipe_r[s].last != 4'd0);
          st_nxt.last = rmd;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        pipe_r[s+1].valid <= 1'b0;
      end else begin
        pipe_r[s+1].valid <= st_nxt.valid;
      end
      pipe_r[s+1].err   <= st_nxt.err;
      pipe_r[s+1].cmd   <= st_nxt.cmd;
      pipe_r[s+1].sign  <= st_nxt.sign;
      pipe_r[s+1].scale <= st_nxt.scale;
      pipe_r[s+1].mag   <= st_nxt.mag;
      pipe_r[s+1].rem   <= st_nxt.rem;
      pipe_r[s+1].last  <= st_nxt.last;
      pipe_r[s+1].rest  <= st_nxt.rest;
    end
  end

  d96r_pkg::stage_t    fin;
  d96r_pkg::out_item_t res_nxt;
  logic                inc;
  logic [95:0]         mag_inc;

  always_comb begin
    fin = pipe_r[NSTG];
    inc = 1'b0;
    if (fin.scale != 5'd0) begin
      case (fin.cmd)
        d96r_pkg::CMD_ROUND:  inc = (fin.last >= 4'd5);
        d96r_pkg::CMD_BANKER: inc = (fin.last > 4'd5) ||
                                    ((fin.last == 4'd5) && (fin.rest || fin.mag[0]));
        d96r_pkg::CMD_FLOOR:  inc = fin.sign && (fin.rest || (fin.last != 4'd0));
        default:              inc = 1'b0;
      endcase
    end
    mag_inc = fin.mag + {95'd0, inc};
    res_nxt = '0;
    if (fin.err) begin
      res_nxt.error = 1'b1;
    end else if (fin.cmd == d96r_pkg::CMD_NEGATE) begin
      res_nxt.out_mant_low  = fin.mag[63:0];
      res_nxt.out_mant_high = fin.mag[95:64];
      res_nxt.out_scale     = fin.scale;
      res_nxt.out_sign      = !fin.sign;
    end else begin
      res_nxt.out_mant_low  = mag_inc[63:0];
      res_nxt.out_mant_high = mag_inc[95:64];
      res_nxt.out_sign      = fin.sign;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= fin.valid;
    end
    out_data_r <= res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: dv/decimal96_round_unit_test.sv
// Self-checking testbench of the decimal round unit.
`timescale 1ns / 1ps

module decimal96_round_unit_test;

  localparam int LATENCY = 6 * 28 + 2;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  d96r_pkg::in_item_t in_data = '0;
  logic out_valid;
  d96r_pkg::out_item_t out_data;

  d96r_pkg::in_item_t pending_items[$];
  d96r_pkg::out_item_t expected_results[$];
  int errors = 0;
  int idle_pct = 0;

  decimal96_round_unit dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_data(in_data), .out_valid(out_valid), .out_data(out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Works out the rounded, truncated, floored or negated decimal value.
  function automatic d96r_pkg::out_item_t round_decimal(d96r_pkg::in_item_t it);
    d96r_pkg::out_item_t r;
    logic [95:0] mag;
    logic [3:0] last;
    logic rest;
    logic inc;
    r = '0;
    last = 4'd0;
    rest = 1'b0;
    inc = 1'b0;
    if (it.scale > 8'd28 || it.command > d96r_pkg::CMD_FLOOR) begin
      r.error = 1'b1;
      return r;
    end
    if (it.command == d96r_pkg::CMD_NEGATE) begin
      r.out_mant_low = it.mant_low;
      r.out_mant_high = it.mant_high;
      r.out_scale = it.scale[4:0];
      r.out_sign = ~it.sign;
      return r;
    end
    mag = {it.mant_high, it.mant_low};
    for (int i = 0; i < it.scale; i++) begin
      if (last != 4'd0) rest = 1'b1;
      last = 4'(mag % 96'd10);
      mag = mag / 96'd10;
    end
    if (it.scale != 0) begin
      case (it.command)
        d96r_pkg::CMD_ROUND: inc = last >= 5;
        d96r_pkg::CMD_BANKER: inc = last > 5 || (last == 5 && (rest || mag[0]));
        d96r_pkg::CMD_FLOOR: inc = it.sign && (rest || last != 0);
        default: inc = 1'b0;
      endcase
    end
    mag = mag + {95'd0, inc};
    r.out_mant_low = mag[63:0];
    r.out_mant_high = mag[95:64];
    r.out_sign = it.sign;
    return r;
  endfunction

  function automatic logic [95:0] random_mag();
    logic [95:0] m;
    m = {$urandom, $urandom, $urandom};
    case ($urandom_range(0, 4))
      0: m = m >> $urandom_range(0, 95);
      1: m = ~96'd0 - $urandom_range(0, 20);
      2: m = m % 96'd1000000;
      default: ;
    endcase
    return m;
  endfunction

  task automatic add_item(logic [2:0] cmd, logic [95:0] m, logic [7:0] scl, logic sgn);
    d96r_pkg::in_item_t it;
    it.command = cmd;
    it.mant_low = m[63:0];
    it.mant_high = m[95:64];
    it.scale = scl;
    it.sign = sgn;
    pending_items.push_back(it);
  endtask

  // Driver: start stays high across back-to-back items.
  always @(posedge clk) begin
    if (rst_n) begin
      if (!(start && busy)) begin
        if (start) expected_results.push_back(round_decimal(in_data));
        if (pending_items.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
          in_data <= pending_items.pop_front();
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: the strobe is taken in the cycle it appears.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data);
        errors++;
      end else begin
        d96r_pkg::out_item_t exp_r;
        exp_r = expected_results.pop_front();
        if (exp_r.out_mant_low !== out_data.out_mant_low) begin
          $display("%0t: mant_low expected %h actual %h", $time, exp_r.out_mant_low,
                   out_data.out_mant_low);
          errors++;
        end
        if (exp_r.out_mant_high !== out_data.out_mant_high) begin
          $display("%0t: mant_high expected %h actual %h", $time, exp_r.out_mant_high,
                   out_data.out_mant_high);
          errors++;
        end
        if (exp_r.out_scale !== out_data.out_scale) begin
          $display("%0t: scale expected %0d actual %0d", $time, exp_r.out_scale,
                   out_data.out_scale);
          errors++;
        end
        if (exp_r.out_sign !== out_data.out_sign) begin
          $display("%0t: sign expected %b actual %b", $time, exp_r.out_sign,
                   out_data.out_sign);
          errors++;
        end
        if (exp_r.error !== out_data.error) begin
          $display("%0t: error expected %b actual %b", $time, exp_r.error, out_data.error);
          errors++;
        end
      end
    end
  end

  task automatic wait_drained();
    while (pending_items.size() > 0 || start || expected_results.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    logic [2:0] cmd;
    logic [7:0] scl;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Extremes, every command, halfway ties, zero scale and rejected items.
    add_item(d96r_pkg::CMD_NEGATE, ~96'd0, 8'd28, 1'b0);
    add_item(d96r_pkg::CMD_NEGATE, 96'd0, 8'd0, 1'b1);
    add_item(d96r_pkg::CMD_TRUNCATE, ~96'd0, 8'd28, 1'b1);
    add_item(d96r_pkg::CMD_TRUNCATE, ~96'd0, 8'd1, 1'b0);
    add_item(d96r_pkg::CMD_ROUND, 96'd25, 8'd1, 1'b1);
    add_item(d96r_pkg::CMD_ROUND, 96'd24, 8'd1, 1'b0);
    add_item(d96r_pkg::CMD_ROUND, ~96'd0, 8'd1, 1'b0);
    add_item(d96r_pkg::CMD_BANKER, 96'd25, 8'd1, 1'b0);
    add_item(d96r_pkg::CMD_BANKER, 96'd35, 8'd1, 1'b1);
    add_item(d96r_pkg::CMD_BANKER, 96'd2501, 8'd3, 1'b0);
    add_item(d96r_pkg::CMD_BANKER, 96'd2500, 8'd3, 1'b0);
    add_item(d96r_pkg::CMD_BANKER, 96'd26, 8'd1, 1'b0);
    add_item(d96r_pkg::CMD_FLOOR, 96'd1000001, 8'd6, 1'b1);
    add_item(d96r_pkg::CMD_FLOOR, 96'd1000000, 8'd6, 1'b1);
    add_item(d96r_pkg::CMD_FLOOR, 96'd1000001, 8'd6, 1'b0);
    add_item(d96r_pkg::CMD_FLOOR, 96'd5, 8'd1, 1'b1);
    add_item(d96r_pkg::CMD_ROUND, 96'd12345, 8'd0, 1'b1);
    add_item(d96r_pkg::CMD_ROUND, 96'd7, 8'd29, 1'b0);
    add_item(d96r_pkg::CMD_NEGATE, ~96'd0, 8'd255, 1'b1);
    add_item(3'd5, 96'd1, 8'd0, 1'b0);
    add_item(3'd7, ~96'd0, 8'd3, 1'b1);
    wait_drained();

    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 18 : (phase == 1) ? 88 : 0;
      for (int n = 0; n < 300; n++) begin
        cmd = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                           : 3'($urandom_range(0, 4));
        case ($urandom_range(0, 9))
          0: scl = 8'($urandom_range(29, 255));
          1: scl = 8'd28;
          2: scl = 8'd0;
          default: scl = 8'($urandom_range(0, 28));
        endcase
        add_item(cmd, random_mag(), scl, 1'($urandom));
        // Let the pipeline empty completely once in the middle of the phase.
        if (n == 150) wait_drained();
      end
      wait_drained();
    end
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0) begin
      $display("decimal96_round_unit_test: PASS");
    end else begin
      $display("decimal96_round_unit_test: FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("decimal96_round_unit_test: FAIL");
    $finish;
  end

endmodule
